[src/fbalc_pkg.sv]
// Shared widths, codes and control types of the first-fit bucket allocator.
`timescale 1ns / 1ps

package fbalc_pkg;

	localparam int BUCKET_CNT_DEF = 64;

	localparam int CFG_W    = 13;
	localparam int SIZE_W   = 19;
	localparam int HANDLE_W = 6;
	localparam int START_W  = 6;
	localparam int OFF_W    = 18;
	// Running byte count of a run: below the request plus one bucket.
	localparam int ACC_W    = 20;

	localparam logic [CFG_W-1:0] BKT_RESET = 13'd64;
	localparam logic [CFG_W-1:0] BKT_MAX   = 13'd4096;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Control from the head unit to every cell of the ring.
	typedef struct packed {
		logic shift;   // rotate the ring by one bucket
		logic commit;  // end of an item: drop all tentative marks
		logic claim;   // with commit: marked cells of the found run become owned
	} fbalc_ctl_t;

endpackage

[src/fbalc_req_if.sv]
// Request channel: valid/ready handshake carrying one allocate or free beat.
`timescale 1ns / 1ps

interface fbalc_req_if import fbalc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [SIZE_W-1:0]   request_size;
	logic [HANDLE_W-1:0] free_handle;

	modport source (output valid, opcode, request_size, free_handle, input ready);
	modport sink (input valid, opcode, request_size, free_handle, output ready);
endinterface

[src/fbalc_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result beat.
`timescale 1ns / 1ps

interface fbalc_rsp_if import fbalc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [START_W-1:0] start_bucket;
	logic [OFF_W-1:0]   byte_offset;

	modport source (output valid, ok, start_bucket, byte_offset, input ready);
	modport sink (input valid, ok, start_bucket, byte_offset, output ready);
endinterface

[src/fbalc_cell.sv]
// One bucket cell of the rotating ring: owned bit, owner tag and tentative mark.
`timescale 1ns / 1ps

module fbalc_cell import fbalc_pkg::*; #(
	parameter int OWN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fbalc_ctl_t       ctl,
	input  logic [OWN_W-1:0] found_start,
	input  logic             nxt_owned,
	input  logic [OWN_W-1:0] nxt_owner,
	input  logic             nxt_mark,
	output logic             owned,
	output logic [OWN_W-1:0] owner,
	output logic             mark
);

	logic             owned_q;
	logic             mark_q;
	logic [OWN_W-1:0] owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owned_q <= 1'b0;
			mark_q  <= 1'b0;
		end else if (ctl.shift) begin
			owned_q <= nxt_owned;
			mark_q  <= nxt_mark;
		end else if (ctl.commit) begin
			// Marks left by abandoned runs carry an older start and are simply dropped.
			if (ctl.claim && mark_q && (owner_q == found_start)) begin
				owned_q <= 1'b1;
			end
			mark_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			owner_q <= nxt_owner;
		end
	end

	assign owned = owned_q;
	assign owner = owner_q;
	assign mark  = mark_q;

endmodule

[src/fbalc_head.sv]
// Head unit: sequencer, bucket-size register and the scan logic at the ring's head cell.
`timescale 1ns / 1ps

module fbalc_head import fbalc_pkg::*; #(
	parameter int BUCKET_CNT = BUCKET_CNT_DEF,
	parameter int OWN_W = $clog2(BUCKET_CNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	fbalc_req_if.sink        req,
	fbalc_rsp_if.source      rsp,
	input  logic             cur_owned,
	input  logic [OWN_W-1:0] cur_owner,
	input  logic             cur_mark,
	output logic             tail_owned,
	output logic [OWN_W-1:0] tail_owner,
	output logic             tail_mark,
	output fbalc_ctl_t       ctl,
	output logic [OWN_W-1:0] found_start
);

	localparam int CMP_W = (OWN_W > HANDLE_W) ? OWN_W : HANDLE_W;
	localparam logic [OWN_W-1:0] LAST_IDX = OWN_W'(BUCKET_CNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    bkt_q;
	logic                op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [OWN_W-1:0]    idx_q;
	logic [OFF_W-1:0]    pos_q;
	logic [ACC_W-1:0]    acc_q;
	logic                run_act_q;
	logic [OWN_W-1:0]    run_start_q;
	logic [OFF_W-1:0]    run_off_q;
	logic                found_q;
	logic [OWN_W-1:0]    found_start_q;
	logic [OFF_W-1:0]    found_off_q;
	logic                freed_q;
	logic                rsp_valid_q;
	logic                rsp_ok_q;
	logic [START_W-1:0]  rsp_start_q;
	logic [OFF_W-1:0]    rsp_off_q;

	logic [CFG_W-1:0] bsz;
	logic [ACC_W-1:0] acc_n;
	logic [OWN_W-1:0] new_start;
	logic [OFF_W-1:0] new_off;
	logic             scan_alloc;
	logic             take;
	logic             hit;
	logic             free_hit;
	logic             accept;
	logic             fire;

	assign bsz        = (bkt_q > BKT_MAX) ? BKT_MAX : bkt_q;
	assign acc_n      = acc_q + ACC_W'(bsz);
	assign new_start  = run_act_q ? run_start_q : idx_q;
	assign new_off    = run_act_q ? run_off_q : pos_q;
	assign scan_alloc = (op_q == OP_ALLOC) && !found_q && (size_q != '0);
	assign take       = scan_alloc && !cur_owned;
	assign hit        = take && (acc_n >= ACC_W'(size_q));
	assign free_hit   = (op_q == OP_FREE) && cur_owned
		&& (CMP_W'(cur_owner) == CMP_W'(handle_q));

	assign accept = req.valid && req.ready;
	assign fire   = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// The head cell goes round to the tail, altered where this item touches it.
	always_comb begin
		tail_owned = cur_owned;
		tail_owner = cur_owner;
		tail_mark  = cur_mark;
		if (take) begin
			tail_mark  = 1'b1;
			tail_owner = new_start;
		end else if (free_hit) begin
			tail_owned = 1'b0;
			tail_owner = '0;
		end
	end

	assign ctl.shift    = (state_q == ST_SCAN);
	assign ctl.commit   = fire;
	assign ctl.claim    = fire && found_q;
	assign found_start  = found_start_q;

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.start_bucket = rsp_start_q;
	assign rsp.byte_offset  = rsp_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_q <= BKT_RESET;
		end else if (cfg_we) begin
			bkt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			found_q     <= 1'b0;
			freed_q     <= 1'b0;
			run_act_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new beat may replace the one taken at this same edge.
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q   <= 1'b0;
						freed_q   <= 1'b0;
						run_act_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_alloc) begin
						run_act_q <= !cur_owned;
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (free_hit) begin
						freed_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.opcode;
			size_q   <= req.request_size;
			handle_q <= req.free_handle;
			idx_q    <= '0;
			pos_q    <= '0;
			acc_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + OWN_W'(1);
			pos_q <= pos_q + OFF_W'(bsz);
			if (scan_alloc) begin
				acc_q <= cur_owned ? '0 : acc_n;
			end
			if (take) begin
				run_start_q <= new_start;
				run_off_q   <= new_off;
			end
			if (hit) begin
				found_start_q <= new_start;
				found_off_q   <= new_off;
			end
		end
		if (fire) begin
			if (op_q == OP_FREE) begin
				rsp_ok_q    <= freed_q;
				rsp_start_q <= '0;
				rsp_off_q   <= '0;
			end else begin
				rsp_ok_q    <= found_q;
				rsp_start_q <= found_q ? START_W'(found_start_q) : '0;
				rsp_off_q   <= found_q ? found_off_q : '0;
			end
		end
	end

endmodule

[src/first_fit_bucket_allocator.sv]
// Top level of the first-fit bucket allocator: ring of bucket cells and its head unit.
//
//   channel  | dir | handshake       | beat contents
//   ---------+-----+-----------------+--------------------------------------------
//   req      | in  | valid / ready   | opcode, request_size, free_handle
//   rsp      | out | valid / ready   | ok, start_bucket, byte_offset
//   cfg      | in  | cfg_we          | cfg_wdata = bucket_bytes
//
// Each request is accepted, then the ring rotates once past the head cell, bucket by
// bucket, and the item commits; a new request is taken only after the last has committed.
// Reset empties the pool at once and sets the bucket size to 64 bytes.
// A result waiting on rsp only holds the commit cycle of the next request.
`timescale 1ns / 1ps

module first_fit_bucket_allocator import fbalc_pkg::*; #(
	parameter int BUCKET_CNT = BUCKET_CNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	fbalc_req_if.sink        req,
	fbalc_rsp_if.source      rsp
);

	localparam int OWN_W = $clog2(BUCKET_CNT);

	fbalc_ctl_t       ctl;
	logic [OWN_W-1:0] found_start;
	logic             tail_owned;
	logic [OWN_W-1:0] tail_owner;
	logic             tail_mark;
	logic             owned_w [BUCKET_CNT];
	logic [OWN_W-1:0] owner_w [BUCKET_CNT];
	logic             mark_w  [BUCKET_CNT];

	fbalc_head #(
		.BUCKET_CNT(BUCKET_CNT),
		.OWN_W(OWN_W)
	) u_head (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp),
		.cur_owned(owned_w[0]),
		.cur_owner(owner_w[0]),
		.cur_mark(mark_w[0]),
		.tail_owned(tail_owned),
		.tail_owner(tail_owner),
		.tail_mark(tail_mark),
		.ctl(ctl),
		.found_start(found_start)
	);

	// Cell k takes from cell k+1 on every shift; the last cell takes the head's output.
	for (genvar k = 0; k < BUCKET_CNT; k++) begin : g_cell
		if (k == BUCKET_CNT - 1) begin : g_tail
			fbalc_cell #(.OWN_W(OWN_W)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.found_start(found_start),
				.nxt_owned(tail_owned),
				.nxt_owner(tail_owner),
				.nxt_mark(tail_mark),
				.owned(owned_w[k]),
				.owner(owner_w[k]),
				.mark(mark_w[k])
			);
		end else begin : g_body
			fbalc_cell #(.OWN_W(OWN_W)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.found_start(found_start),
				.nxt_owned(owned_w[k+1]),
				.nxt_owner(owner_w[k+1]),
				.nxt_mark(mark_w[k+1]),
				.owned(owned_w[k]),
				.owner(owner_w[k]),
				.mark(mark_w[k])
			);
		end
	end

endmodule

[src/fbalc_chk.sv]
// Port-level checker for the first-fit bucket allocator, bound to the top level.
`timescale 1ns / 1ps

module fbalc_chk import fbalc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_ok,
	input logic [START_W-1:0] rsp_start_bucket,
	input logic [OFF_W-1:0]   rsp_byte_offset
);

	// A response beat must not be withdrawn or altered while it waits.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_bucket)
			&& $stable(rsp_byte_offset) && $stable(rsp_ok))
		else $error("response beat changed while stalled");

	// The block is busy scanning right after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during a scan");

	// A request cannot produce its result in the very next cycle.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared too early");

	// Failures report a zero start and offset (frees do too, but only failures are checked here).
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_start_bucket == '0 && rsp_byte_offset == '0)
		else $error("failed response carries a start or offset");

endmodule

bind first_fit_bucket_allocator fbalc_chk u_fbalc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_ok(rsp.ok),
	.rsp_start_bucket(rsp.start_bucket),
	.rsp_byte_offset(rsp.byte_offset)
);

[tb/sv/fbalc_checker.sv]
// Checker for the bucket allocator: mirrors the pool, predicts each result and compares.
`timescale 1ns / 1ps

module fbalc_checker import fbalc_pkg::*; #(
	parameter int NB = BUCKET_CNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	fbalc_req_if             req,
	fbalc_rsp_if             rsp,
	output int               outstanding,
	output int               mismatches,
	output int               grants,
	output int               releases,
	output int               refusals
);

	typedef struct packed {
		logic               ok;
		logic [START_W-1:0] start_bucket;
		logic [OFF_W-1:0]   byte_offset;
	} alloc_result_t;

	logic [CFG_W-1:0] bucket_bytes;
	logic             owned [NB];
	int unsigned      run_head [NB];
	alloc_result_t    awaited [$];
	alloc_result_t    predicted;

	initial begin
		mismatches = 0;
		grants     = 0;
		releases   = 0;
		refusals   = 0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// First fit from bucket 0; the run grows until it covers the request.
	function automatic alloc_result_t claim_first_fit(input logic [SIZE_W-1:0] want);
		alloc_result_t res;
		int unsigned   unit;
		int unsigned   first;
		int unsigned   len;
		bit            found;
		res   = '0;
		found = 1'b0;
		first = 0;
		len   = 0;
		unit  = (bucket_bytes > BKT_MAX) ? 32'(BKT_MAX) : 32'(bucket_bytes);
		if (want == 0 || unit == 0)
			return res;
		for (int i = 0; i < NB && !found; i++) begin
			if (owned[i]) begin
				len = 0;
			end else begin
				if (len == 0)
					first = i;
				len++;
				if (len * unit >= 32'(want))
					found = 1'b1;
			end
		end
		if (!found)
			return res;
		for (int i = first; i < first + len; i++) begin
			owned[i]    = 1'b1;
			run_head[i] = first;
		end
		res.ok           = 1'b1;
		res.start_bucket = START_W'(first);
		res.byte_offset  = OFF_W'(first * unit);
		return res;
	endfunction

	function automatic alloc_result_t release_run(input logic [HANDLE_W-1:0] handle);
		alloc_result_t res;
		res = '0;
		for (int i = 0; i < NB; i++) begin
			if (owned[i] && run_head[i] == 32'(handle)) begin
				owned[i]    = 1'b0;
				run_head[i] = 0;
				res.ok      = 1'b1;
			end
		end
		return res;
	endfunction

	task automatic check_result();
		alloc_result_t want;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing awaited: ok=%0b start=%0d offset=%0d",
				rsp.ok, rsp.start_bucket, rsp.byte_offset));
			return;
		end
		want = awaited.pop_front();
		if (rsp.ok !== want.ok || rsp.start_bucket !== want.start_bucket
				|| rsp.byte_offset !== want.byte_offset)
			report_mismatch($sformatf("got ok=%0b start=%0d offset=%0d, awaited ok=%0b start=%0d offset=%0d",
				rsp.ok, rsp.start_bucket, rsp.byte_offset,
				want.ok, want.start_bucket, want.byte_offset));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_bytes = BKT_RESET;
			for (int i = 0; i < NB; i++) begin
				owned[i]    = 1'b0;
				run_head[i] = 0;
			end
			awaited.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				bucket_bytes = cfg_wdata;
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready) begin
				if (req.opcode == OP_ALLOC)
					predicted = claim_first_fit(req.request_size);
				else
					predicted = release_run(req.free_handle);
				if (!predicted.ok)
					refusals++;
				else if (req.opcode == OP_ALLOC)
					grants++;
				else
					releases++;
				awaited.push_back(predicted);
			end
			// Written nonblocking, which keeps the stimulus's idle test free of races.
			outstanding <= awaited.size();
		end
	end

endmodule

[tb/sv/first_fit_bucket_allocator_test.sv]
// Testbench top for the bucket allocator: clock, reset, stimulus, response pacing and verdict.
`timescale 1ns / 1ps

module first_fit_bucket_allocator_test;
	import fbalc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 800;
	localparam int unsigned MAX_SIZE = (1 << SIZE_W) - 1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int outstanding;
	int mismatches;
	int grants;
	int releases;
	int refusals;
	int cycle_count = 0;

	bit               hold_req;
	int               burst_left;
	int               sender_gap_max;
	logic [CFG_W-1:0] bucket_setting;

	fbalc_req_if req_ch ();
	fbalc_rsp_if rsp_ch ();

	first_fit_bucket_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	fbalc_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.outstanding (outstanding),
		.mismatches  (mismatches),
		.grants      (grants),
		.releases    (releases),
		.refusals    (refusals)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one beat; valid is only lowered when a gap opens, so bursts stay back to back.
	task automatic send_item(input logic op, input logic [SIZE_W-1:0] size,
			input logic [HANDLE_W-1:0] handle);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (sender_gap_max > 0)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
					: $urandom_range(0, sender_gap_max);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.request_size <= size;
		req_ch.free_handle  <= handle;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	task automatic alloc_req(input int unsigned size);
		send_item(OP_ALLOC, SIZE_W'(size), HANDLE_W'($urandom));
	endtask

	task automatic free_req(input int unsigned handle);
		send_item(OP_FREE, SIZE_W'($urandom), HANDLE_W'(handle));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_bucket_bytes(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bucket_setting = value;
	endtask

	task automatic free_every_handle();
		for (int h = 0; h < BUCKET_CNT_DEF; h++)
			free_req(h);
	endtask

	// Mixed frees and allocations; sizes near bucket multiples give runs of every length.
	task automatic random_items(input int count);
		int unsigned eb;
		int unsigned pick;
		int unsigned v;
		eb = (bucket_setting > BKT_MAX) ? 32'(BKT_MAX) : 32'(bucket_setting);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if (pick < 30)
					free_req($urandom_range(0, 15));
				else
					free_req($urandom);
			end else begin
				if (pick < 50)
					v = 0;
				else if (pick < 58)
					v = $urandom;
				else if (eb == 0)
					v = $urandom_range(1, 4096);
				else if (pick < 70)
					v = eb * $urandom_range(1, 64) + $urandom_range(0, 2) - 1;
				else
					v = $urandom_range(1, eb * $urandom_range(1, 6));
				if (pick >= 58 && v > MAX_SIZE)
					v = MAX_SIZE;
				alloc_req(v);
			end
		end
	endtask

	initial begin : rsp_pacer
		int stall_pct;
		int mode_left;
		int hold_left;
		bit held;
		stall_pct = 0;
		mode_left = 0;
		hold_left = 0;
		held      = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held      = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(30, 400);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				mode_left--;
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin : stimulus
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= OP_ALLOC;
		req_ch.request_size <= '0;
		req_ch.free_handle  <= '0;
		hold_req       = 1'b0;
		burst_left     = 0;
		sender_gap_max = 0;
		bucket_setting = BKT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default 64-byte buckets: refusals, a whole-pool run and first-fit reuse of a hole.
		alloc_req(0);
		alloc_req(262144);
		alloc_req(4096);
		alloc_req(1);
		free_req(0);
		free_req(0);
		alloc_req(1);
		alloc_req(65);
		alloc_req(64);
		free_req(1);
		alloc_req(128);
		free_req(63);
		alloc_req(4096);
		alloc_req(3840);
		sender_gap_max = 70;
		random_items(40);
		sender_gap_max = 3;
		free_every_handle();

		// An oversized bucket is clamped to 4096, which reaches the largest byte offset.
		write_bucket_bytes(13'd8191);
		alloc_req(258048);
		alloc_req(4096);
		alloc_req(1);
		free_req(63);
		free_req(0);
		alloc_req(262144);
		free_req(0);
		random_items(40);

		// Zero-byte buckets refuse every allocation.
		write_bucket_bytes('0);
		alloc_req(1);
		alloc_req(262144);
		random_items(30);
		free_every_handle();

		write_bucket_bytes(13'd1);
		alloc_req(64);
		alloc_req(65);
		free_req(0);
		alloc_req(65);
		random_items(40);

		sender_gap_max = 70;
		write_bucket_bytes(13'd4096);
		random_items(40);
		sender_gap_max = 0;
		write_bucket_bytes(13'd4095);
		random_items(40);
		sender_gap_max = 3;
		write_bucket_bytes(CFG_W'($urandom_range(1, 4096)));
		random_items(40);
		write_bucket_bytes(CFG_W'($urandom_range(0, 8191)));
		random_items(40);

		// Results are held back for a long stretch while requests keep coming.
		write_bucket_bytes(BKT_RESET);
		sender_gap_max = 0;
		hold_req = 1'b1;
		random_items(40);

		drain_results();
		repeat (BUCKET_CNT_DEF + 4) @(posedge clk);
		$display("Checked %0d result beats: %0d allocations granted, %0d runs released, %0d refused.",
			grants + releases + refusals, grants, releases, refusals);
		$display("Bucket sizes 0, 1, 64, 4095, 4096 and a clamped 8191 were used, plus a long stall.");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
